// ===== hw/rtl/qae_pkg.sv =====
package qae_pkg;

   localparam int unsigned MaxValueBytes   = 254;
   localparam int unsigned MaxKeywordBytes = 8;

   localparam logic [7:0] SingleQuote = 8'h27;
   localparam logic [7:0] DoubleQuote = 8'h22;

   localparam logic [1:0] PhaseHunt  = 2'd0;
   localparam logic [1:0] PhaseSkip  = 2'd1;
   localparam logic [1:0] PhaseQuote = 2'd2;
   localparam logic [1:0] PhaseValue = 2'd3;

   localparam logic       CsrKeywordBytes  = 1'b0;
   localparam logic       CsrKeywordLength = 1'b1;

   localparam logic [63:0] KeywordBytesReset  = 64'h0000_0000_6665_7268;
   localparam logic [3:0]  KeywordLengthReset = 4'd4;

   typedef struct packed {
      logic [7:0] doc_byte;
      logic       doc_end;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value_byte;
      logic       value_end;
      logic       value_truncated;
   } result_type;

   function automatic logic is_quote(input logic [7:0] b);
      return (b == SingleQuote) || (b == DoubleQuote);
   endfunction

endpackage

// ===== hw/rtl/qae_in_stage.sv =====
module qae_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qae_pkg::item_type req_item,
   input  logic              drain,
   output logic              item_valid,
   output qae_pkg::item_type item
);
   import qae_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || drain;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== hw/rtl/qae_scanner.sv =====
module qae_scanner (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  qae_pkg::item_type   item,
   input  logic [63:0]         keyword_bytes,
   input  logic [3:0]          keyword_length,
   output qae_pkg::result_type result
);
   import qae_pkg::*;

   logic [3:0] match_count_ff;
   logic [3:0] match_count_in;
   logic [1:0] phase_ff;
   logic [1:0] phase_in;
   logic [7:0] value_length_ff;
   logic [7:0] value_length_in;
   logic       overflowed_ff;
   logic       overflowed_in;

   logic [3:0] len_used;
   logic [3:0] mc_start;
   logic [3:0] mc_next;
   logic [7:0] kw_sel;
   logic [7:0] kw_first;

   always_comb begin
      if (keyword_length == 4'd0) begin
         len_used = 4'd1;
      end else if (keyword_length > 4'(MaxKeywordBytes)) begin
         len_used = 4'(MaxKeywordBytes);
      end else begin
         len_used = keyword_length;
      end
   end

   assign mc_start = (match_count_ff >= len_used) ? 4'd0 : match_count_ff;
   assign kw_sel   = keyword_bytes[{mc_start[2:0], 3'b000} +: 8];
   assign kw_first = keyword_bytes[7:0];

   always_comb begin
      if (item.doc_byte == kw_sel) begin
         mc_next = mc_start + 4'd1;
      end else if (item.doc_byte == kw_first) begin
         mc_next = 4'd1;
      end else begin
         mc_next = 4'd0;
      end
   end

   always_comb begin
      match_count_in  = match_count_ff;
      phase_in        = phase_ff;
      value_length_in = value_length_ff;
      overflowed_in   = overflowed_ff;
      result          = '0;
      case (phase_ff)
         PhaseHunt: begin
            if (mc_next >= len_used) begin
               match_count_in = 4'd0;
               phase_in       = PhaseSkip;
            end else begin
               match_count_in = mc_next;
            end
         end
         PhaseSkip: begin
            phase_in = PhaseQuote;
         end
         PhaseQuote: begin
            if (is_quote(item.doc_byte)) begin
               phase_in        = PhaseValue;
               value_length_in = 8'd0;
               overflowed_in   = 1'b0;
            end else begin
               phase_in = PhaseHunt;
            end
         end
         PhaseValue: begin
            if (is_quote(item.doc_byte)) begin
               result.valid           = 1'b1;
               result.value_end       = 1'b1;
               result.value_truncated = overflowed_ff;
               phase_in               = PhaseHunt;
               value_length_in        = 8'd0;
               overflowed_in          = 1'b0;
            end else if (item.doc_end) begin
               result.valid           = 1'b1;
               result.value_end       = 1'b1;
               result.value_truncated = 1'b1;
            end else if (value_length_ff < 8'(MaxValueBytes)) begin
               result.valid      = 1'b1;
               result.value_byte = item.doc_byte;
               value_length_in   = value_length_ff + 8'd1;
            end else begin
               overflowed_in = 1'b1;
            end
         end
         default: begin
            phase_in = PhaseHunt;
         end
      endcase
      if (item.doc_end) begin
         phase_in        = PhaseHunt;
         match_count_in  = 4'd0;
         value_length_in = 8'd0;
         overflowed_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_count_ff  <= 4'd0;
         phase_ff        <= PhaseHunt;
         value_length_ff <= 8'd0;
         overflowed_ff   <= 1'b0;
      end else if (step) begin
         match_count_ff  <= match_count_in;
         phase_ff        <= phase_in;
         value_length_ff <= value_length_in;
         overflowed_ff   <= overflowed_in;
      end
   end

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      value_length_ff <= 8'(MaxValueBytes))
      else $error("value length past limit");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PhaseValue) |-> (value_length_ff == 8'd0 && !overflowed_ff))
      else $error("value state left over outside a value");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflowed_ff |-> (value_length_ff == 8'(MaxValueBytes)))
      else $error("overflow flagged before limit reached");

   a_doc_end_hunt: assert property (@(posedge clock) disable iff (reset)
      (step && item.doc_end) |=> (phase_ff == PhaseHunt && match_count_ff == 4'd0))
      else $error("scanner not back to hunting after document end");

endmodule

// ===== hw/rtl/qae_out_stage.sv =====
module qae_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  qae_pkg::result_type result,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_value_byte,
   output logic                rsp_value_end,
   output logic                rsp_value_truncated
);
   import qae_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] value_byte_ff;
   logic       value_end_ff;
   logic       value_truncated_ff;

   assign space               = !valid_ff || rsp_ready;
   assign rsp_valid           = valid_ff;
   assign rsp_value_byte      = value_byte_ff;
   assign rsp_value_end       = value_end_ff;
   assign rsp_value_truncated = value_truncated_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_byte_ff      <= result.value_byte;
         value_end_ff       <= result.value_end;
         value_truncated_ff <= result.value_truncated;
      end
   end

endmodule

// ===== hw/rtl/quoted_attribute_extractor.sv =====
// Scans a document one byte per request for a keyword (reset "href", case-sensitive),
// skips the byte after it, and if the next byte is a single or double quote returns every
// following byte as a value byte until either quote arrives, which returns an end marker.
// Values longer than 254 bytes are cut short and flagged on the end marker; a document
// end inside a value closes it as truncated. A request enters an input register, is
// scanned by one pass of compare and phase logic, and lands in a result register, so one
// request is taken every cycle while the result side keeps up. Keyword registers are to
// be written on the csr port only while the block is idle; the block does not enforce it.
module quoted_attribute_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_doc_byte,
   input  logic        req_doc_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_value_byte,
   output logic        rsp_value_end,
   output logic        rsp_value_truncated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   import qae_pkg::*;

   logic [63:0] keyword_bytes_ff;
   logic [3:0]  keyword_length_ff;

   item_type    req_item;
   item_type    item;
   logic        item_valid;
   logic        step;
   logic        space;
   logic        load;
   result_type  result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_bytes_ff  <= KeywordBytesReset;
         keyword_length_ff <= KeywordLengthReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrKeywordBytes:  keyword_bytes_ff  <= csr_data;
            CsrKeywordLength: keyword_length_ff <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   assign req_item.doc_byte = req_doc_byte;
   assign req_item.doc_end  = req_doc_end;

   assign step = item_valid && (!result.valid || space);
   assign load = step && result.valid;

   qae_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .drain      (step),
      .item_valid (item_valid),
      .item       (item)
   );

   qae_scanner u_scanner (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (item),
      .keyword_bytes  (keyword_bytes_ff),
      .keyword_length (keyword_length_ff),
      .result         (result)
   );

   qae_out_stage u_out_stage (
      .clock               (clock),
      .reset               (reset),
      .load                (load),
      .result              (result),
      .space               (space),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value_byte      (rsp_value_byte),
      .rsp_value_end       (rsp_value_end),
      .rsp_value_truncated (rsp_value_truncated)
   );

endmodule

// ===== test/tb_quoted_attribute_extractor.sv =====
`timescale 1ns / 1ps

module tb_quoted_attribute_extractor;
   import qae_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned PhaseItems = 165;
   localparam int unsigned HoldCycles = 300;
   localparam int unsigned NumPhases  = 8;
   localparam logic [7:0]  EqualSign  = 8'h3D;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       value_end;
      logic       value_truncated;
   } extract_type;

   typedef struct packed {
      bit          pinned;
      bit          has_result;
      extract_type res;
   } pin_type;

   typedef struct packed {
      logic [7:0]  doc_byte;
      logic        doc_end;
      bit          pinned;
      bit          has_result;
      extract_type res;
   } dir_row_type;

   // reset keyword "href", length 4
   localparam dir_row_type DirRows [25] = '{
      '{8'h68, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h68, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h72, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h65, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h66, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h3D, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h22, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b0}},
      '{8'h68, 1'b0, 1'b1, 1'b1, '{8'h68, 1'b0, 1'b0}},
      '{8'h27, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{8'h68, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h72, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h65, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h66, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h3D, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h78, 1'b1, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h68, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h72, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h65, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h66, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h3D, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h27, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h61, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{8'h62, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}
   };

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [7:0]  req_doc_byte        = 8'h00;
   logic        req_doc_end         = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [7:0]  rsp_value_byte;
   logic        rsp_value_end;
   logic        rsp_value_truncated;
   logic        csr_valid           = 1'b0;
   logic        csr_ready;
   logic        csr_index           = 1'b0;
   logic [63:0] csr_data            = 64'h0;

   always #1 clock = ~clock;

   quoted_attribute_extractor i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_doc_byte        (req_doc_byte),
      .req_doc_end         (req_doc_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value_byte      (rsp_value_byte),
      .rsp_value_end       (rsp_value_end),
      .rsp_value_truncated (rsp_value_truncated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // scanner copy
   logic [63:0] kw_q;
   logic [3:0]  kw_len_q;
   logic [3:0]  match_q;
   logic [1:0]  phase_q;
   logic [7:0]  vlen_q;
   logic        ovf_q;

   extract_type expected_values [$];
   pin_type     pinned_q [$];

   int unsigned errors        = 0;
   int unsigned n_value_bytes = 0;
   int unsigned n_ends        = 0;
   int unsigned n_truncated   = 0;
   int unsigned cycle_count   = 0;

   // driver side
   int unsigned send_idle_pct = 0;
   int unsigned n_sent        = 0;
   logic [63:0] cfg_kw        = KeywordBytesReset;
   logic [3:0]  cfg_len       = KeywordLengthReset;

   // receiver control
   int unsigned stall_pct = 0;
   int unsigned hold_seq  = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   function automatic bit extract_step(input logic [7:0] b, input logic last,
                                       output extract_type r);
      logic [3:0] len;
      logic [7:0] kb;
      bit         quote;
      bit         has;
      len = (kw_len_q == 4'd0) ? 4'd1 : kw_len_q;
      if (len > MaxKeywordBytes) len = 4'(MaxKeywordBytes);
      quote = (b == SingleQuote) || (b == DoubleQuote);
      has = 1'b0;
      r = '0;
      case (phase_q)
         PhaseHunt: begin
            if (match_q >= len) match_q = 4'd0;
            kb = 8'(kw_q >> {match_q[2:0], 3'b000});
            if (b == kb) match_q = match_q + 4'd1;
            else match_q = (b == kw_q[7:0]) ? 4'd1 : 4'd0;
            if (match_q >= len) begin
               match_q = 4'd0;
               phase_q = PhaseSkip;
            end
         end
         PhaseSkip: begin
            phase_q = PhaseQuote;
         end
         PhaseQuote: begin
            if (quote) begin
               phase_q = PhaseValue;
               vlen_q  = 8'd0;
               ovf_q   = 1'b0;
            end else begin
               phase_q = PhaseHunt;
            end
         end
         default: begin
            if (quote) begin
               has = 1'b1;
               r.value_end = 1'b1;
               r.value_truncated = ovf_q;
               phase_q = PhaseHunt;
               vlen_q  = 8'd0;
               ovf_q   = 1'b0;
            end else if (last) begin
               has = 1'b1;
               r.value_end = 1'b1;
               r.value_truncated = 1'b1;
               vlen_q = 8'd0;
               ovf_q  = 1'b0;
            end else if (vlen_q < MaxValueBytes) begin
               has = 1'b1;
               r.value_byte = b;
               vlen_q = vlen_q + 8'd1;
            end else begin
               ovf_q = 1'b1;
            end
         end
      endcase
      if (last) begin
         phase_q = PhaseHunt;
         match_q = 4'd0;
         vlen_q  = 8'd0;
         ovf_q   = 1'b0;
      end
      return has;
   endfunction

   always @(posedge clock) begin : result_check
      extract_type got;
      extract_type want;
      extract_type pred;
      pin_type     pin;
      bit          has;
      if (reset) begin
         kw_q     = KeywordBytesReset;
         kw_len_q = KeywordLengthReset;
         match_q  = 4'd0;
         phase_q  = PhaseHunt;
         vlen_q   = 8'd0;
         ovf_q    = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.value_byte      = rsp_value_byte;
            got.value_end       = rsp_value_end;
            got.value_truncated = rsp_value_truncated;
            if (expected_values.size() == 0) begin
               $error("unexpected result: value_byte %0h value_end %0b value_truncated %0b",
                      got.value_byte, got.value_end, got.value_truncated);
               errors++;
            end else begin
               want = expected_values.pop_front();
               if (got.value_byte !== want.value_byte) begin
                  $error("value_byte: expected %0h, actual %0h", want.value_byte,
                         got.value_byte);
                  errors++;
               end
               if (got.value_end !== want.value_end) begin
                  $error("value_end: expected %0b, actual %0b", want.value_end,
                         got.value_end);
                  errors++;
               end
               if (got.value_truncated !== want.value_truncated) begin
                  $error("value_truncated: expected %0b, actual %0b", want.value_truncated,
                         got.value_truncated);
                  errors++;
               end
               if (want.value_end) begin
                  n_ends++;
                  if (want.value_truncated) n_truncated++;
               end else begin
                  n_value_bytes++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrKeywordBytes) kw_q = csr_data;
            else kw_len_q = csr_data[3:0];
         end
         if (req_valid && req_ready) begin
            pin = pinned_q.pop_front();
            has = extract_step(req_doc_byte, req_doc_end, pred);
            if (pin.pinned) begin
               if (pin.has_result) expected_values.push_back(pin.res);
            end else if (has) begin
               expected_values.push_back(pred);
            end
         end
      end
   end

   // receiver, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HoldCycles;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_values.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic bit rare_end(input int unsigned odds);
      return $urandom_range(odds - 1) == 0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last, input pin_type pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pinned_q.push_back(pin);
      req_valid    <= 1'b1;
      req_doc_byte <= b;
      req_doc_end  <= last;
      do @(posedge clock); while (!req_ready);
      n_sent++;
   endtask

   task automatic send_free(input logic [7:0] b, input logic last);
      send_byte(b, last, '0);
   endtask

   task automatic write_keyword(input logic [63:0] kw, input logic [3:0] len);
      logic [63:0] fill;
      fill = {$urandom, $urandom};
      csr_valid <= 1'b1;
      csr_index <= CsrKeywordBytes;
      csr_data  <= kw;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CsrKeywordLength;
      csr_data  <= {fill[63:4], len};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_kw  = kw;
      cfg_len = len;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_values.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // noise, keyword (sometimes broken), skip byte, quote, value, closing quote
   task automatic send_sequence();
      int unsigned n;
      int          cut;
      int unsigned k;
      int unsigned eff;
      logic [7:0]  b;
      eff = (cfg_len == 4'd0) ? 1 : ((cfg_len > MaxKeywordBytes) ? MaxKeywordBytes : cfg_len);
      n = $urandom_range(0, 3);
      repeat (n) begin
         k = $urandom_range(0, 7);
         b = $urandom_range(1) ? cfg_kw[8*k +: 8] : 8'($urandom);
         send_free(b, rare_end(40));
      end
      if ($urandom_range(9) == 0) return;
      cut = ($urandom_range(7) == 0) ? int'($urandom_range(0, eff - 1)) : -1;
      for (int i = 0; i < eff; i++) begin
         b = cfg_kw[8*i +: 8];
         if (i == cut) b = 8'($urandom);
         send_free(b, (i == eff - 1) && rare_end(20));
      end
      send_free(($urandom_range(3) != 0) ? EqualSign : 8'($urandom), rare_end(40));
      if ($urandom_range(99) < 85) b = $urandom_range(1) ? SingleQuote : DoubleQuote;
      else b = 8'($urandom);
      send_free(b, rare_end(40));
      n = ($urandom_range(29) == 0) ? $urandom_range(250, 258) : $urandom_range(0, 12);
      repeat (n) begin
         b = 8'($urandom);
         if ((b == SingleQuote || b == DoubleQuote) && $urandom_range(9) != 0) b = b ^ 8'h40;
         send_free(b, rare_end(80));
      end
      case ($urandom_range(9))
         0: send_free(8'($urandom), 1'b1);
         1: send_free($urandom_range(1) ? SingleQuote : DoubleQuote, 1'b1);
         default: send_free($urandom_range(1) ? SingleQuote : DoubleQuote, 1'b0);
      endcase
   endtask

   initial begin
      int unsigned phase_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 0;
      foreach (DirRows[i]) begin
         send_byte(DirRows[i].doc_byte, DirRows[i].doc_end,
                   '{1'b1 & DirRows[i].pinned, DirRows[i].has_result, DirRows[i].res});
      end
      settle();

      for (int p = 0; p < NumPhases; p++) begin
         case (p)
            0: write_keyword(KeywordBytesReset, KeywordLengthReset);
            1: write_keyword({$urandom, $urandom}, 4'd8);
            2: write_keyword({$urandom, $urandom}, 4'd1);
            3: write_keyword({$urandom, $urandom}, 4'd0);
            4: write_keyword(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
            5: write_keyword(64'h0, 4'd8);
            6: write_keyword({$urandom, $urandom}, 4'($urandom_range(2, 7)));
            default: write_keyword({$urandom, $urandom}, 4'($urandom_range(0, 15)));
         endcase
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 68;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 68;
            end
            default: begin
               send_idle_pct = 29;
               stall_pct <= 29;
            end
         endcase
         // receiver holds off while requests keep coming
         if (p == 4) hold_seq <= hold_seq + 1;
         phase_start = n_sent;
         while (n_sent - phase_start < PhaseItems) send_sequence();
         settle();
      end

      $display("scanned %0d document bytes under %0d keyword settings, with idle and stall mixes",
               n_sent, NumPhases + 1);
      $display("compared %0d value bytes and %0d end markers (%0d truncated)",
               n_value_bytes, n_ends, n_truncated);
      if (errors == 0 && expected_values.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
